// ----- src/stgdr_pkg.sv -----
`timescale 1ns / 1ps

package stgdr_pkg;

    // line and table geometry
    localparam int NS    = 4096;
    localparam int IDX_W = 12;
    localparam int CNT_W = 13;

    // clamp limits of the sea-level position, Q16.16
    localparam logic signed [63:0] POS_LIM = 64'(NS - 1) <<< 16;
    localparam logic signed [63:0] POS_TOP = 64'(NS - 2) <<< 16;

    // request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_GAP_FILL   = 2'd0;
    localparam logic [1:0] CFG_MAX_BREAK  = 2'd1;
    localparam logic [1:0] CFG_BAD_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_NO_DATA    = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [IDX_W-1:0]   pixel_index;
        logic signed [31:0] ground_entry;
        logic signed [31:0] shift_entry;
        logic signed [31:0] height;
        logic               first_of_line;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]   read_index;
        logic signed [31:0] ground_height;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic tbl_wr;
        logic first_init;
        logic clr_wr;
        logic mul;
        logic pos;
        logic g1_sel;
        logic g0_cap;
        logic fmul;
        logic gsum;
        logic gx;
        logic div_start;
        logic fill_nd;
        logic fill_div;
        logic fill_wr;
        logic track;
        logic rsp_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] in_type;
        logic       in_first;
        logic       clr_last;
        logic       overrun;
        logic       smp_ok;
        logic       nd_fill;
        logic       interp;
        logic       run_pos;
        logic       div_done;
        logic       fill_last;
        logic       rsp_free;
    } t_sts;

endpackage

// ----- src/stgdr_div.sv -----
`timescale 1ns / 1ps

module stgdr_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [32:0]  i_dividend,
    input  logic [12:0]         i_divisor,
    output logic                o_done,
    output logic signed [32:0]  o_quot
);
    import stgdr_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [13:0] r_rem;
    logic [32:0] r_quo;
    logic [12:0] r_dvs;
    logic        r_neg;
    logic [13:0] rem_sh;
    logic        fits;

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem[12:0], r_quo[32]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd32) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[32] ? 33'(-i_dividend) : i_dividend;
            r_neg <= i_dividend[32];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sh - {1'b0, r_dvs} : rem_sh;
            r_quo <= {r_quo[31:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

// ----- src/stgdr_dp.sv -----
`timescale 1ns / 1ps

module stgdr_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stgdr_pkg::t_cmd  i_cmd,
    output stgdr_pkg::t_sts  o_sts,
    input  stgdr_pkg::t_req  i_req,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output stgdr_pkg::t_rsp  o_rsp
);
    import stgdr_pkg::*;

    // configuration
    logic               r_gap_fill;
    logic [12:0]        r_max_break;
    logic signed [31:0] r_bad;
    logic signed [31:0] r_nd;

    // memories
    logic [31:0] gtab [NS];
    logic [31:0] stab [NS];
    logic [31:0] line [NS];
    logic signed [31:0] r_g_rd;
    logic signed [31:0] r_s_rd;
    logic signed [31:0] r_l_rd;

    // latched item and trackers
    logic [IDX_W-1:0]   r_idx;
    logic signed [31:0] r_h;
    logic [CNT_W-1:0]   r_slant;
    logic signed [12:0] r_last_idx;
    logic signed [31:0] r_last_h;
    logic signed [31:0] r_clr_val;
    logic [IDX_W-1:0]   r_clr_cnt;

    // sample pipeline
    logic signed [63:0] r_prod;
    logic [IDX_W-1:0]   r_i;
    logic [15:0]        r_f;
    logic signed [31:0] r_g0;
    logic signed [49:0] r_fprod;
    logic signed [34:0] r_g;
    logic [IDX_W-1:0]   r_gx;
    logic               r_ok;

    // fill
    logic [IDX_W-1:0]   r_fptr;
    logic [31:0]        r_fval;
    logic [31:0]        r_step;

    // response
    logic               r_rsp_valid;
    t_rsp               r_rsp;

    logic signed [63:0] pos;
    logic signed [63:0] pos_c;
    logic [IDX_W-1:0]   g_addr;
    logic signed [32:0] gdiff;
    logic signed [49:0] fq_adj;
    logic signed [33:0] fq;
    logic signed [34:0] g_adj;
    logic signed [18:0] gx;
    logic signed [13:0] run_n;
    logic signed [32:0] d_last;
    logic signed [32:0] d_h;
    logic               near_last;
    logic               near_h;
    logic signed [32:0] quot;
    logic               l_we;
    logic [IDX_W-1:0]   l_waddr;
    logic [31:0]        l_wdata;
    logic [12:0]        fptr_init;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_fill  <= 1'b1;
            r_max_break <= 13'd5;
            r_bad       <= 32'sh8000_0000;
            r_nd        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAP_FILL:   r_gap_fill  <= i_cfg_data[0];
                CFG_MAX_BREAK:  r_max_break <= i_cfg_data[12:0];
                CFG_BAD_HEIGHT: r_bad       <= $signed(i_cfg_data);
                CFG_NO_DATA:    r_nd        <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // ground and shift tables
    assign g_addr = i_cmd.g1_sel ? r_i + 12'd1 : r_i;

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr) begin
            gtab[i_req.pixel_index] <= i_req.ground_entry;
            stab[i_req.pixel_index] <= i_req.shift_entry;
        end
        r_g_rd <= gtab[g_addr];
        r_s_rd <= stab[r_slant[IDX_W-1:0]];
    end

    // ground line: clear sweep or run fill, one read port for pixel reads
    assign l_we    = i_cmd.clr_wr | i_cmd.fill_wr;
    assign l_waddr = i_cmd.clr_wr ? r_clr_cnt : r_fptr;
    assign l_wdata = i_cmd.clr_wr ? r_clr_val : r_fval;

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            line[l_waddr] <= l_wdata;
        end
        r_l_rd <= line[r_idx];
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= i_req.pixel_index;
            r_h   <= i_req.height;
        end
    end

    // trackers, clear value and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slant    <= '0;
            r_last_idx <= -13'sd1;
            r_last_h   <= 32'sh8000_0000;
            r_clr_val  <= '0;
            r_clr_cnt  <= '0;
        end else begin
            if (i_cmd.first_init) begin
                r_slant    <= '0;
                r_last_idx <= -13'sd1;
                r_last_h   <= r_bad;
                r_clr_val  <= r_bad;
            end
            if (i_cmd.pos) begin
                r_slant <= r_slant + 13'd1;
            end
            if (i_cmd.track) begin
                r_last_h   <= r_h;
                r_last_idx <= $signed({1'b0, r_gx});
            end
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + 12'd1;
            end
        end
    end

    // sea-level position, clamped
    assign pos = $signed({36'd0, r_slant[IDX_W-1:0], 16'd0}) - (r_prod >>> 24);

    always_comb begin
        if (pos < 0) begin
            pos_c = '0;
        end else if (pos >= POS_LIM) begin
            pos_c = POS_TOP;
        end else begin
            pos_c = pos;
        end
    end

    // ground interpolation, truncating divisions by 2^16
    assign gdiff  = 33'(r_g_rd) - 33'(r_g0);
    assign fq_adj = r_fprod + (r_fprod[49] ? 50'sd65535 : 50'sd0);
    assign fq     = 34'(fq_adj >>> 16);
    assign g_adj  = r_g + (r_g[34] ? 35'sd65535 : 35'sd0);
    assign gx     = 19'(g_adj >>> 16);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= 64'(r_h) * 64'(r_s_rd);
        end
        if (i_cmd.pos) begin
            r_i <= pos_c[27:16];
            r_f <= pos_c[15:0];
        end
        if (i_cmd.g0_cap) begin
            r_g0 <= r_g_rd;
        end
        if (i_cmd.fmul) begin
            r_fprod <= $signed({1'b0, r_f}) * gdiff;
        end
        if (i_cmd.gsum) begin
            r_g <= 35'(r_g0) + 35'(fq);
        end
        if (i_cmd.gx) begin
            r_gx <= gx[IDX_W-1:0];
            r_ok <= (r_h > r_bad) && (gx[18:IDX_W] == '0);
        end
    end

    // run decisions
    assign run_n     = $signed({2'b00, r_gx}) - 14'(r_last_idx);
    assign d_last    = 33'(r_last_h) - 33'(r_nd);
    assign d_h       = 33'(r_h) - 33'(r_nd);
    assign near_last = (d_last >= -33'sd6) && (d_last <= 33'sd6);
    assign near_h    = (d_h >= -33'sd6) && (d_h <= 33'sd6);

    stgdr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (33'(r_h) - 33'(r_last_h)),
        .i_divisor  (run_n[12:0]),
        .o_done     (o_sts.div_done),
        .o_quot     (quot)
    );

    // run fill
    assign fptr_init = r_last_idx + 13'sd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_nd) begin
            r_fptr <= fptr_init[IDX_W-1:0];
            r_fval <= r_nd;
            r_step <= '0;
        end else if (i_cmd.fill_div) begin
            r_fptr <= fptr_init[IDX_W-1:0];
            r_fval <= r_last_h + quot[31:0];
            r_step <= quot[31:0];
        end else if (i_cmd.fill_wr) begin
            r_fptr <= r_fptr + 12'd1;
            r_fval <= r_fval + r_step;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.rsp_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rsp_load) begin
            r_rsp.read_index    <= r_idx;
            r_rsp.ground_height <= r_l_rd;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // status
    assign o_sts.in_type   = i_req.req_type;
    assign o_sts.in_first  = i_req.first_of_line;
    assign o_sts.clr_last  = r_clr_cnt == IDX_W'(NS - 1);
    assign o_sts.overrun   = r_slant[CNT_W-1];
    assign o_sts.smp_ok    = r_ok;
    assign o_sts.nd_fill   = near_last | near_h;
    assign o_sts.run_pos   = run_n > 0;
    assign o_sts.interp    = (r_last_h != r_bad) && (run_n > 0)
                           && (r_gap_fill || (run_n < $signed({1'b0, r_max_break})));
    assign o_sts.fill_last = r_fptr == r_gx;
    assign o_sts.rsp_free  = !r_rsp_valid || i_rsp_ready;

endmodule

// ----- src/stgdr_ctrl.sv -----
`timescale 1ns / 1ps

module stgdr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  stgdr_pkg::t_sts  i_sts,
    output stgdr_pkg::t_cmd  o_cmd
);
    import stgdr_pkg::*;

    typedef enum logic [15:0] {
        ST_RCLR = 16'h0001,
        ST_IDLE = 16'h0002,
        ST_LCLR = 16'h0004,
        ST_CHK  = 16'h0008,
        ST_MUL  = 16'h0010,
        ST_POS  = 16'h0020,
        ST_G0   = 16'h0040,
        ST_G1   = 16'h0080,
        ST_FMUL = 16'h0100,
        ST_GSUM = 16'h0200,
        ST_GX   = 16'h0400,
        ST_DEC  = 16'h0800,
        ST_DIV  = 16'h1000,
        ST_FILL = 16'h2000,
        ST_READ = 16'h4000,
        ST_RSP  = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc;

    assign o_req_ready = r_state == ST_IDLE;
    assign acc         = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RCLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_RCLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) begin
                    o_cmd.accept = 1'b1;
                    case (i_sts.in_type)
                        REQ_LOAD: o_cmd.tbl_wr = 1'b1;
                        REQ_SAMPLE: begin
                            if (i_sts.in_first) begin
                                o_cmd.first_init = 1'b1;
                                n_state = ST_LCLR;
                            end else begin
                                n_state = ST_CHK;
                            end
                        end
                        REQ_READ: n_state = ST_READ;
                        default: ;
                    endcase
                end
            end
            ST_LCLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = ST_CHK;
            end
            ST_CHK: begin
                n_state = i_sts.overrun ? ST_IDLE : ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_POS;
            end
            ST_POS: begin
                o_cmd.pos = 1'b1;
                n_state = ST_G0;
            end
            ST_G0: begin
                n_state = ST_G1;
            end
            ST_G1: begin
                o_cmd.g1_sel = 1'b1;
                o_cmd.g0_cap = 1'b1;
                n_state = ST_FMUL;
            end
            ST_FMUL: begin
                o_cmd.fmul = 1'b1;
                n_state = ST_GSUM;
            end
            ST_GSUM: begin
                o_cmd.gsum = 1'b1;
                n_state = ST_GX;
            end
            ST_GX: begin
                o_cmd.gx = 1'b1;
                n_state = ST_DEC;
            end
            ST_DEC: begin
                n_state = ST_IDLE;
                if (i_sts.smp_ok) begin
                    if (i_sts.nd_fill) begin
                        if (i_sts.run_pos) begin
                            o_cmd.fill_nd = 1'b1;
                            n_state = ST_FILL;
                        end else begin
                            o_cmd.track = 1'b1;
                        end
                    end else if (i_sts.interp) begin
                        o_cmd.div_start = 1'b1;
                        n_state = ST_DIV;
                    end else begin
                        o_cmd.track = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.fill_div = 1'b1;
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_sts.fill_last) begin
                    o_cmd.track = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_RSP;
            end
            ST_RSP: begin
                if (i_sts.rsp_free) begin
                    o_cmd.rsp_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- src/slant_to_ground_dem_resampler_unit.sv -----
`timescale 1ns / 1ps
// channel   | direction | handshake                   | payload
// request   | in        | i_req_valid / o_req_ready   | i_req (t_req)
// response  | out       | o_rsp_valid / i_rsp_ready   | o_rsp (t_rsp)
// config    | in        | i_cfg_we                    | i_cfg_index, i_cfg_data
//
// a load is written as accepted; a read passes ST_READ and ST_RSP, plus any
// wait on the response register; a sample runs ST_CHK to ST_DEC (ST_CHK alone
// past the line end), ST_DIV for the step divider when it interpolates, and
// ST_FILL, one ground pixel filled per cycle; the first sample of a line
// sweeps the line memory first; after reset the sweep zeroes it, ready low
// a stalled response holds its register; the next item is still taken

module slant_to_ground_dem_resampler_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  stgdr_pkg::t_req  i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output stgdr_pkg::t_rsp  o_rsp,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data
);
    import stgdr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    stgdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // tables, line memory and arithmetic
    stgdr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- src/stgdr_chk.sv -----
`timescale 1ns / 1ps

module stgdr_chk (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             o_req_ready,
    input  stgdr_pkg::t_req  i_req,
    input  logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    input  stgdr_pkg::t_rsp  o_rsp,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data
);
    import stgdr_pkg::*;

    logic acc;
    assign acc = i_req_valid && o_req_ready;

    // reset starts the memory sweep, so no item is taken right after
    a_rst_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_req_ready)
        else $error("ready high right after reset");

    // samples and reads occupy the sequencer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_req.req_type == REQ_SAMPLE || i_req.req_type == REQ_READ)
        |=> !o_req_ready)
        else $error("ready held through a sample or read");

    // a read into an empty response register is answered with its pixel index
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_req.req_type == REQ_READ && !o_rsp_valid
        |-> ##3 (o_rsp_valid && o_rsp.read_index == $past(i_req.pixel_index, 3)))
        else $error("read response missing or wrong index");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");

endmodule

bind slant_to_ground_dem_resampler_unit stgdr_chk u_chk (.*);
